// ===== hdl/ldr_literal_xref_finder_top_defines.svh =====
// ============================================================================
// Assertion macros for the literal cross-reference finder checker.
// ============================================================================
`ifndef LDR_LITERAL_XREF_FINDER_TOP_DEFINES_SVH
`define LDR_LITERAL_XREF_FINDER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LXF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LXF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// ===== hdl/lxf_pkg.sv =====
// ============================================================================
// lxf_pkg
// Types and constants shared by the literal cross-reference finder.
// ============================================================================
package lxf_pkg;

    // Search windows below the literal, in bytes.
    localparam logic [31:0] NEAR_WINDOW = 32'h0000_0420;
    localparam logic [31:0] FAR_WINDOW  = 32'h0000_1000;

    // Thumb encodings of the first halfword.
    localparam logic [15:0] NARROW_MASK    = 16'hF800;
    localparam logic [15:0] NARROW_PATTERN = 16'h4800;
    localparam logic [15:0] WIDE_PATTERN   = 16'hF8DF;

    // Configuration port: byte address width and register word indexes.
    localparam int unsigned PADDR_W = 3;
    localparam logic [0:0]  REG_LITERAL_ADDRESS = 1'b0;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_NARROW = 2'd1,
        KIND_WIDE   = 2'd2
    } match_kind_t;

    typedef struct packed {
        logic [31:0] position_address;
        logic [31:0] code_word;
        logic        last_position;
    } in_word_t;

    typedef struct packed {
        match_kind_t match_kind;
        logic [31:0] match_address;
    } out_word_t;

    // Hits found at one code position.
    typedef struct packed {
        logic narrow;
        logic wide;
    } hit_t;

endpackage

// ===== hdl/lxf_match.sv =====
// ============================================================================
// lxf_match
// Decodes one code position and tests both load forms against the literal.
// ============================================================================
module lxf_match (
    input  logic [31:0]  position_address,
    input  logic [31:0]  code_word,
    input  logic [31:0]  literal_address,
    output lxf_pkg::hit_t hit
);
    import lxf_pkg::*;

    logic [15:0] first_half;
    logic [31:0] distance;
    logic [31:0] base;
    logic [31:0] narrow_target;
    logic [31:0] wide_target;

    // The PC seen by the load is the word-aligned position plus four.
    assign first_half    = code_word[15:0];
    assign distance      = literal_address - position_address;
    assign base          = (position_address + 32'd4) & ~32'd3;
    assign narrow_target = base + {22'd0, code_word[7:0], 2'b00};
    assign wide_target   = base + {20'd0, code_word[27:16]};

    // A position above the literal wraps to a large distance and never hits.
    assign hit.narrow = ((first_half & NARROW_MASK) == NARROW_PATTERN) &&
                        (distance < NEAR_WINDOW) && (narrow_target == literal_address);
    assign hit.wide   = (first_half == WIDE_PATTERN) &&
                        (distance < FAR_WINDOW) && (wide_target == literal_address);

endmodule

// ===== hdl/ldr_literal_xref_finder_top.sv =====
// ============================================================================
// ldr_literal_xref_finder_top
// Finds the Thumb literal load that references a configured literal address.
// ============================================================================
// Usage:
// Code positions stream in on the in channel (in_valid, in_stall, in_data) in
// descending address order, one word per cycle while in_stall is low. Each word carries the
// position, the 32-bit code found there and a flag that marks the last one.
// The closest narrow LDR and the closest wide LDR.W hit are kept; the word
// that closes a scan produces one result word on the out channel, preferring
// the narrow hit, and the search state clears for the next scan.
// A closing word passes the input register and then the decode and compare
// into the output register, where it raises out_valid.
// Throughput is one word per cycle, set by the single decode stage; words
// that do not close a scan keep flowing while a result waits on out_stall.
// A closing word waits in the input register while the output register is
// still held by the receiver, and in_stall rises only then.
// Reset clears the literal address, the search state and both valid flags.
// literal_address is written through the APB port at byte address 0.
// ============================================================================
module ldr_literal_xref_finder_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  lxf_pkg::in_word_t           in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output lxf_pkg::out_word_t          out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lxf_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import lxf_pkg::*;

    logic        literal_sel;
    logic [31:0] literal_reg;
    logic [31:0] literal_next;

    logic        s1_valid_reg;
    logic        s1_valid_next;
    in_word_t    s1_data_reg;
    in_word_t    s1_data_next;

    logic        narrow_found_reg;
    logic        narrow_found_next;
    logic [31:0] narrow_address_reg;
    logic [31:0] narrow_address_next;
    logic        wide_found_reg;
    logic        wide_found_next;
    logic [31:0] wide_address_reg;
    logic [31:0] wide_address_next;

    logic        out_valid_reg;
    logic        out_valid_next;
    out_word_t   out_data_reg;
    out_word_t   out_data_next;

    logic        slot_free;
    logic        s1_advance;
    logic        take;
    logic        cfg_write;
    hit_t        hit;
    logic        narrow_eff;
    logic [31:0] narrow_addr_eff;
    logic        wide_eff;
    logic [31:0] wide_addr_eff;

    // Register select: the word index sits above the byte offset.
    assign literal_sel = (paddr[PADDR_W-1:2] == REG_LITERAL_ADDRESS);

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && literal_sel;
    assign prdata    = literal_sel ? literal_reg : 32'd0;

    always_comb
    begin
        literal_next = literal_reg;
        if (cfg_write)
        begin
            literal_next = pwdata;
        end
    end

    // Handshake: a closing word needs the output register to be free.
    assign slot_free  = !out_valid_reg || !out_stall;
    assign s1_advance = s1_valid_reg && (!s1_data_reg.last_position || slot_free);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign take       = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_data_next  = s1_data_reg;
        if (take)
        begin
            s1_valid_next = 1'b1;
            s1_data_next  = in_data;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    lxf_match u_match (
        .position_address (s1_data_reg.position_address),
        .code_word        (s1_data_reg.code_word),
        .literal_address  (literal_reg),
        .hit              (hit)
    );

    // The first hit of each kind is kept; later ones are farther away.
    assign narrow_eff      = narrow_found_reg || hit.narrow;
    assign narrow_addr_eff = narrow_found_reg ? narrow_address_reg
                                              : s1_data_reg.position_address;
    assign wide_eff        = wide_found_reg || hit.wide;
    assign wide_addr_eff   = wide_found_reg ? wide_address_reg
                                            : s1_data_reg.position_address;

    // Search state: updated per word, cleared after the closing word.
    always_comb
    begin
        narrow_found_next   = narrow_found_reg;
        narrow_address_next = narrow_address_reg;
        wide_found_next     = wide_found_reg;
        wide_address_next   = wide_address_reg;
        if (s1_advance)
        begin
            if (s1_data_reg.last_position)
            begin
                narrow_found_next   = 1'b0;
                narrow_address_next = 32'd0;
                wide_found_next     = 1'b0;
                wide_address_next   = 32'd0;
            end
            else
            begin
                narrow_found_next   = narrow_eff;
                narrow_address_next = narrow_eff ? narrow_addr_eff : 32'd0;
                wide_found_next     = wide_eff;
                wide_address_next   = wide_eff ? wide_addr_eff : 32'd0;
            end
        end
    end

    // Output register: loaded by the closing word, held while stalled.
    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        if (s1_advance && s1_data_reg.last_position)
        begin
            out_valid_next = 1'b1;
            if (narrow_eff)
            begin
                out_data_next.match_kind    = KIND_NARROW;
                out_data_next.match_address = narrow_addr_eff;
            end
            else if (wide_eff)
            begin
                out_data_next.match_kind    = KIND_WIDE;
                out_data_next.match_address = wide_addr_eff;
            end
            else
            begin
                out_data_next.match_kind    = KIND_NONE;
                out_data_next.match_address = 32'd0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Control and search state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            literal_reg        <= 32'd0;
            s1_valid_reg       <= 1'b0;
            narrow_found_reg   <= 1'b0;
            narrow_address_reg <= 32'd0;
            wide_found_reg     <= 1'b0;
            wide_address_reg   <= 32'd0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            literal_reg        <= literal_next;
            s1_valid_reg       <= s1_valid_next;
            narrow_found_reg   <= narrow_found_next;
            narrow_address_reg <= narrow_address_next;
            wide_found_reg     <= wide_found_next;
            wide_address_reg   <= wide_address_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        s1_data_reg  <= s1_data_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ===== hdl/lxf_checker.sv =====
// ============================================================================
// lxf_checker
// Port-level checks on the literal cross-reference finder, bound to the top.
// ============================================================================
`include "ldr_literal_xref_finder_top_defines.svh"

module lxf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input lxf_pkg::in_word_t           in_data,
    input logic                        out_valid,
    input logic                        out_stall,
    input lxf_pkg::out_word_t          out_data
);
    import lxf_pkg::*;

    // A result with no hit carries a zero address.
    `LXF_ASSERT_NOW(a_none_zero, out_valid && (out_data.match_kind == KIND_NONE), out_data.match_address == 32'd0)

    // A stalled result word holds.
    `LXF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

    // An empty output register never backs up the input.
    `LXF_ASSERT_NOW(a_no_false_stall, !out_valid, !in_stall)

    // A new result follows a closing word that was accepted on the input.
    `LXF_ASSERT_NOW(a_result_latency, $rose(out_valid), $past(in_valid && !in_stall && in_data.last_position, 2))

endmodule

bind ldr_literal_xref_finder_top lxf_checker u_lxf_checker (.*);
